>>> rtl/escnd_pkg.sv
package escnd_pkg;

  // Characters the decoder reacts to
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  // Escape kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_HEX  = 2'd1;
  localparam logic [1:0] KIND_DEC  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_OK  = 2'd0;
  localparam logic [1:0] ERR_HEX = 2'd1;
  localparam logic [1:0] ERR_DEC = 2'd2;

  // Most results one character can cause
  localparam int MAX_RES = 3;

  typedef struct packed {
    logic       outside_quotes;
    logic       quote_seen;
    logic [1:0] escape_kind;
    logic [1:0] escape_fill;
    logic       error_hold;
  } state_t;

  localparam state_t ST_RESET = '{
    outside_quotes: 1'b1,
    quote_seen:     1'b0,
    escape_kind:    KIND_NONE,
    escape_fill:    2'd0,
    error_hold:     1'b0
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] error_code;
  } result_t;

  // Outcome of the ordinary rules on one character
  typedef struct packed {
    logic emit;
    logic outside_quotes;
    logic quote_seen;
  } plain_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // Ordinary rules: quote toggling and doubling, space dropping.
  // When emit is set the emitted byte is always the character itself.
  function automatic plain_t plain_char(logic oq, logic qs, logic [7:0] c);
    plain_t p;
    p.emit           = 1'b0;
    p.outside_quotes = oq;
    p.quote_seen     = 1'b0;
    if (qs && c == CH_QUOTE) begin
      p.outside_quotes = ~oq;
      p.emit           = 1'b1;
    end else if (c == CH_QUOTE) begin
      p.outside_quotes = ~oq;
      p.quote_seen     = 1'b1;
    end else if (!(c == CH_SPACE && oq)) begin
      p.emit = 1'b1;
    end
    return p;
  endfunction

  function automatic digit_t hex_digit(logic [7:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = 4'd0;
    if (c inside {[CH_0:CH_9]}) begin
      d.val = 4'(c - CH_0);
    end else if (c inside {[CH_UA:CH_UF]}) begin
      d.val = 4'(c - CH_UA + 8'd10);
    end else if (c inside {[CH_LA:CH_LF]}) begin
      d.val = 4'(c - CH_LA + 8'd10);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  function automatic digit_t dec_digit(logic [7:0] c);
    digit_t d;
    d.ok  = 1'b0;
    d.val = 4'd0;
    if (c inside {[CH_0:CH_9]}) begin
      d.ok  = 1'b1;
      d.val = 4'(c - CH_0);
    end
    return d;
  endfunction

endpackage

>>> rtl/escape_number_decoder.sv
// Command line escape decoder. One character enters per transfer on the
// s_ side with s_tlast on the last character of a line; decoded results
// leave on the m_ side. Each character yields zero to three results, and
// the result buffer sends one result per cycle while m_tready is high, so
// a character that yields several results holds the input until its last
// result is sent, and one that yields at most one keeps the stream at one
// character per cycle. m_tuser marks the last result caused by a
// character, m_tlast the final result of a line; a line always ends with
// at least one result, a marker-only one (byte_valid low, error_code zero)
// when nothing else came out.
module escape_number_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_char
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] byte_valid, [10:9] error_code
  output logic        m_tlast,
  output logic        m_tuser    // [0] run_last
);

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_end;
  logic       take;
  logic       free;
  logic [1:0] res_cnt;
  escnd_pkg::result_t [escnd_pkg::MAX_RES-1:0] res;

  // Input register moves into the result buffer when that frees up
  assign take     = in_valid && free;
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_end  <= s_tlast;
    end
  end

  escnd_step u_step (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .in_char  (in_char),
    .line_end (in_end),
    .res      (res),
    .res_cnt  (res_cnt)
  );

  escnd_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .res_in   (res),
    .cnt_in   (res_cnt),
    .eol_in   (in_end),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

>>> rtl/escnd_step.sv
module escnd_step (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         take,
  input  logic [7:0]                                   in_char,
  input  logic                                         line_end,
  output escnd_pkg::result_t [escnd_pkg::MAX_RES-1:0]  res,
  output logic [1:0]                                   res_cnt
);

  escnd_pkg::state_t st;
  escnd_pkg::state_t st_next;
  logic [7:0]        escape_chars [2];

  escnd_pkg::plain_t p0, p1, p2, pc;
  escnd_pkg::digit_t h0, h1, d0, d1, d2;
  logic [9:0]        dec_sum;
  logic              finishing;
  logic              stash;
  logic [2:0]        cand_emit;
  escnd_pkg::result_t [2:0] cand;
  logic [1:0]        n;

  always_comb begin
    st_next   = st;
    cand_emit = 3'b000;
    cand      = '0;
    stash     = 1'b0;
    res       = '0;
    n         = 2'd0;

    // Digit decoders and the decimal value
    h0 = escnd_pkg::hex_digit(escape_chars[0]);
    h1 = escnd_pkg::hex_digit(in_char);
    d0 = escnd_pkg::dec_digit(escape_chars[0]);
    d1 = escnd_pkg::dec_digit(escape_chars[1]);
    d2 = escnd_pkg::dec_digit(in_char);
    dec_sum = 10'(d0.val) * 10'd100 + 10'(d1.val) * 10'd10 + 10'(d2.val);

    finishing = (st.escape_kind == escnd_pkg::KIND_HEX) ? (st.escape_fill >= 2'd1)
                                                        : (st.escape_fill >= 2'd2);

    // Replay chain for a line that ends inside an escape
    p0 = escnd_pkg::plain_char(st.outside_quotes, st.quote_seen,
                               (st.escape_kind == escnd_pkg::KIND_HEX) ?
                               escnd_pkg::CH_HASH : escnd_pkg::CH_AMP);
    p1 = (st.escape_fill == 2'd1) ?
         escnd_pkg::plain_char(p0.outside_quotes, p0.quote_seen, escape_chars[0]) : p0;
    p2 = escnd_pkg::plain_char(p1.outside_quotes, p1.quote_seen, in_char);

    // Ordinary rules on the current character
    pc = escnd_pkg::plain_char(st.outside_quotes, st.quote_seen, in_char);

    if (st.error_hold) begin
      // rest of the line is ignored
    end else if (st.escape_kind != escnd_pkg::KIND_NONE) begin
      if (finishing) begin
        cand_emit[0] = 1'b1;
        if (st.escape_kind == escnd_pkg::KIND_HEX) begin
          if (h0.ok && h1.ok) begin
            cand[0] = '{out_byte: {h0.val, h1.val}, byte_valid: 1'b1,
                        error_code: escnd_pkg::ERR_OK};
          end else begin
            cand[0] = '{out_byte: 8'd0, byte_valid: 1'b0, error_code: escnd_pkg::ERR_HEX};
            st_next.error_hold = 1'b1;
          end
        end else begin
          if (d0.ok && d1.ok && d2.ok) begin
            cand[0] = '{out_byte: dec_sum[7:0], byte_valid: 1'b1,
                        error_code: escnd_pkg::ERR_OK};
          end else begin
            cand[0] = '{out_byte: 8'd0, byte_valid: 1'b0, error_code: escnd_pkg::ERR_DEC};
            st_next.error_hold = 1'b1;
          end
        end
        st_next.escape_kind = escnd_pkg::KIND_NONE;
        st_next.escape_fill = 2'd0;
      end else if (line_end) begin
        // marker, buffered digit, current character by the ordinary rules
        cand_emit[0] = p0.emit;
        cand[0]      = '{out_byte: (st.escape_kind == escnd_pkg::KIND_HEX) ?
                         escnd_pkg::CH_HASH : escnd_pkg::CH_AMP,
                         byte_valid: 1'b1, error_code: escnd_pkg::ERR_OK};
        cand_emit[1] = (st.escape_fill == 2'd1) && p1.emit;
        cand[1]      = '{out_byte: escape_chars[0], byte_valid: 1'b1,
                         error_code: escnd_pkg::ERR_OK};
        cand_emit[2] = p2.emit;
        cand[2]      = '{out_byte: in_char, byte_valid: 1'b1, error_code: escnd_pkg::ERR_OK};
      end else begin
        stash               = 1'b1;
        st_next.escape_fill = st.escape_fill + 2'd1;
      end
    end else begin
      if (!(st.quote_seen && in_char == escnd_pkg::CH_QUOTE) &&
          (in_char == escnd_pkg::CH_HASH || in_char == escnd_pkg::CH_AMP) &&
          st.outside_quotes && !line_end) begin
        // start of an escape
        st_next.quote_seen  = 1'b0;
        st_next.escape_kind = (in_char == escnd_pkg::CH_HASH) ?
                              escnd_pkg::KIND_HEX : escnd_pkg::KIND_DEC;
        st_next.escape_fill = 2'd0;
      end else begin
        cand_emit[0]           = pc.emit;
        cand[0]                = '{out_byte: in_char, byte_valid: 1'b1,
                                   error_code: escnd_pkg::ERR_OK};
        st_next.outside_quotes = pc.outside_quotes;
        st_next.quote_seen     = pc.quote_seen;
      end
    end

    // Pack the emitted candidates in order
    for (int i = 0; i < 3; i++) begin
      if (cand_emit[i]) begin
        res[n] = cand[i];
        n      = n + 2'd1;
      end
    end

    // Line end: marker-only result if nothing came out, then back to reset
    if (line_end) begin
      if (n == 2'd0) begin
        res[0] = '{out_byte: 8'd0, byte_valid: 1'b0, error_code: escnd_pkg::ERR_OK};
        n      = 2'd1;
      end
      st_next = escnd_pkg::ST_RESET;
    end
    res_cnt = n;
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= escnd_pkg::ST_RESET;
    end else if (take) begin
      st <= st_next;
    end
  end

  // Digit buffer, no reset
  always_ff @(posedge clk) begin
    if (take && stash) begin
      escape_chars[st.escape_fill[0]] <= in_char;
    end
  end

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    take && line_end |=> st == escnd_pkg::ST_RESET)
    else $error("state not back to reset after line end");

  a_eol_has_result: assert property (@(posedge clk) disable iff (rst)
    take && line_end |-> res_cnt != 2'd0)
    else $error("line end produced no result");

  a_held_after_error: assert property (@(posedge clk) disable iff (rst)
    take && st.error_hold |-> st_next.error_hold || line_end)
    else $error("error hold dropped inside a line");

endmodule

>>> rtl/escnd_outq.sv
module escnd_outq (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         load,
  input  escnd_pkg::result_t [escnd_pkg::MAX_RES-1:0]  res_in,
  input  logic [1:0]                                   cnt_in,
  input  logic                                         eol_in,
  output logic                                         free,
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  output logic [15:0]                                  m_tdata,
  output logic                                         m_tlast,
  output logic                                         m_tuser
);

  escnd_pkg::result_t [escnd_pkg::MAX_RES-1:0] res;
  logic [1:0] cnt;
  logic [1:0] idx;
  logic       eol;
  logic       last;
  escnd_pkg::result_t cur;

  // Current result and its markers
  assign last     = (idx == cnt - 2'd1);
  assign cur      = res[idx];
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = {5'd0, cur.error_code, cur.byte_valid, cur.out_byte};
  assign m_tuser  = last;
  assign m_tlast  = last && eol;
  assign free     = (cnt == 2'd0) || (m_tready && last);

  // Control: result count and read position
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= cnt_in;
      idx <= 2'd0;
    end else if (m_tvalid && m_tready) begin
      if (last) begin
        cnt <= 2'd0;
        idx <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
      eol <= eol_in;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> idx < cnt)
    else $error("read position past result count");

  a_eol_is_run_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("end of line not on last result of its character");

endmodule

>>> verif/escape_number_decoder_test.sv
module escape_number_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_CHARS = 375;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;

  // One decoded result as it should leave the block
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] error_code;
    logic       run_last;
    logic       end_of_line;
  } decoded_t;

  // Directed stimulus row; the result is typed in only where typed is set
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    logic [7:0] t_byte;
    logic       t_valid;
    logic [1:0] t_err;
  } dir_row_t;

  localparam int DIR_ROWS = 33;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  // Decoder shadow state
  logic       line_outside;
  logic       pending_quote;
  logic [1:0] esc_kind;
  int         esc_fill;
  logic [7:0] esc_digits [2];
  logic       skip_line;

  decoded_t step_res [$];
  decoded_t decoded_q [$];

  int  fail_cnt    = 0;
  int  cycle_cnt   = 0;
  int  chars_sent  = 0;
  int  lines_sent  = 0;
  int  results_cnt = 0;
  int  errors_cnt  = 0;
  bit  no_idle     = 1'b0;
  int  rx_hold     = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // hex escape, both letter cases
    '{escnd_pkg::CH_HASH,  1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{"f",                 1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{"F",                 1'b0, 1'b1, 8'hFF, 1'b1, escnd_pkg::ERR_OK},
    // decimal escape, top value and wraparound
    '{escnd_pkg::CH_AMP,   1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{"2",                 1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{"5",                 1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{"5",                 1'b0, 1'b1, 8'hFF, 1'b1, escnd_pkg::ERR_OK},
    '{escnd_pkg::CH_AMP,   1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{escnd_pkg::CH_9,     1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{escnd_pkg::CH_9,     1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{escnd_pkg::CH_9,     1'b0, 1'b1, 8'hE7, 1'b1, escnd_pkg::ERR_OK},
    // quoted space, doubled quote, marker char ending a line inside quotes
    '{escnd_pkg::CH_QUOTE, 1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{escnd_pkg::CH_SPACE, 1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{escnd_pkg::CH_QUOTE, 1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{escnd_pkg::CH_QUOTE, 1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{escnd_pkg::CH_HASH,  1'b1, 1'b1, escnd_pkg::CH_HASH, 1'b1, escnd_pkg::ERR_OK},
    // dropped space alone on a line
    '{escnd_pkg::CH_SPACE, 1'b1, 1'b1, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    // bad hex digit, then the rest of the line is ignored
    '{escnd_pkg::CH_HASH,  1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{"g",                 1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{escnd_pkg::CH_0,     1'b0, 1'b1, 8'h00, 1'b0, escnd_pkg::ERR_HEX},
    '{8'hFF,               1'b1, 1'b1, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    // line ends inside a decimal escape on a doubled quote, one half buffered
    '{escnd_pkg::CH_AMP,   1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{escnd_pkg::CH_QUOTE, 1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{escnd_pkg::CH_QUOTE, 1'b1, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    // zero byte, then bad middle decimal digit, escape closing on the last char
    '{8'h00,               1'b0, 1'b1, 8'h00, 1'b1, escnd_pkg::ERR_OK},
    '{escnd_pkg::CH_AMP,   1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{"1",                 1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{"x",                 1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{"2",                 1'b1, 1'b1, 8'h00, 1'b0, escnd_pkg::ERR_DEC},
    // line ends inside a hex escape
    '{escnd_pkg::CH_HASH,  1'b0, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    '{"7",                 1'b1, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK},
    // marker on the last char, lone quote at line end
    '{escnd_pkg::CH_AMP,   1'b1, 1'b1, escnd_pkg::CH_AMP, 1'b1, escnd_pkg::ERR_OK},
    '{escnd_pkg::CH_QUOTE, 1'b1, 1'b1, 8'h00, 1'b0, escnd_pkg::ERR_OK}
  };

  escape_number_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------

  function automatic int hex_val(logic [7:0] c);
    if (c >= escnd_pkg::CH_0 && c <= escnd_pkg::CH_9)
      return int'(c - escnd_pkg::CH_0);
    if (c >= escnd_pkg::CH_UA && c <= escnd_pkg::CH_UF)
      return int'(c - escnd_pkg::CH_UA) + 10;
    if (c >= escnd_pkg::CH_LA && c <= escnd_pkg::CH_LF)
      return int'(c - escnd_pkg::CH_LA) + 10;
    return -1;
  endfunction

  function automatic int dec_val(logic [7:0] c);
    if (c >= escnd_pkg::CH_0 && c <= escnd_pkg::CH_9)
      return int'(c - escnd_pkg::CH_0);
    return -1;
  endfunction

  task automatic clear_state();
    line_outside  = 1'b1;
    pending_quote = 1'b0;
    esc_kind      = escnd_pkg::KIND_NONE;
    esc_fill      = 0;
    skip_line     = 1'b0;
  endtask

  task automatic add_res(input logic [7:0] b, input logic v, input logic [1:0] e);
    if (step_res.size() < escnd_pkg::MAX_RES)
      step_res.push_back(decoded_t'{b, v, e, 1'b0, 1'b0});
  endtask

  // Quote toggling and doubling, space dropping; never opens an escape
  task automatic plain_rule(input logic [7:0] c);
    if (pending_quote) begin
      pending_quote = 1'b0;
      if (c == escnd_pkg::CH_QUOTE) begin
        line_outside = ~line_outside;
        add_res(escnd_pkg::CH_QUOTE, 1'b1, escnd_pkg::ERR_OK);
        return;
      end
    end
    if (c == escnd_pkg::CH_QUOTE) begin
      line_outside  = ~line_outside;
      pending_quote = 1'b1;
    end else if (!(c == escnd_pkg::CH_SPACE && line_outside)) begin
      add_res(c, 1'b1, escnd_pkg::ERR_OK);
    end
  endtask

  task automatic close_escape(input logic [7:0] c);
    int h, l, a, b, d;
    if (esc_kind == escnd_pkg::KIND_HEX) begin
      h = hex_val(esc_digits[0]);
      l = hex_val(c);
      if (h < 0 || l < 0) begin
        add_res(8'h00, 1'b0, escnd_pkg::ERR_HEX);
        skip_line = 1'b1;
      end else begin
        add_res(8'(h * 16 + l), 1'b1, escnd_pkg::ERR_OK);
      end
    end else begin
      a = dec_val(esc_digits[0]);
      b = dec_val(esc_digits[1]);
      d = dec_val(c);
      if (a < 0 || b < 0 || d < 0) begin
        add_res(8'h00, 1'b0, escnd_pkg::ERR_DEC);
        skip_line = 1'b1;
      end else begin
        add_res(8'(a * 100 + b * 10 + d), 1'b1, escnd_pkg::ERR_OK);
      end
    end
    esc_kind = escnd_pkg::KIND_NONE;
    esc_fill = 0;
  endtask

  // Fills step_res with the results one accepted char causes
  task automatic decode_char(input logic [7:0] c, input logic last);
    logic taken;
    int   need;
    step_res.delete();
    taken = 1'b0;
    need  = (esc_kind == escnd_pkg::KIND_HEX) ? 2 : 3;
    if (skip_line) begin
      // rest of line ignored after a bad digit
    end else if (esc_kind != escnd_pkg::KIND_NONE) begin
      if (esc_fill + 1 >= need) begin
        close_escape(c);
      end else if (last) begin
        // line cut short: replay marker and digits as plain chars
        plain_rule(esc_kind == escnd_pkg::KIND_HEX ?
                   escnd_pkg::CH_HASH : escnd_pkg::CH_AMP);
        for (int i = 0; i < esc_fill; i++) plain_rule(esc_digits[i]);
        plain_rule(c);
        esc_kind = escnd_pkg::KIND_NONE;
        esc_fill = 0;
      end else begin
        esc_digits[esc_fill] = c;
        esc_fill++;
      end
    end else begin
      if (pending_quote) begin
        pending_quote = 1'b0;
        if (c == escnd_pkg::CH_QUOTE) begin
          line_outside = ~line_outside;
          add_res(escnd_pkg::CH_QUOTE, 1'b1, escnd_pkg::ERR_OK);
          taken = 1'b1;
        end
      end
      if (!taken) begin
        if ((c == escnd_pkg::CH_HASH || c == escnd_pkg::CH_AMP) &&
            line_outside && !last) begin
          esc_kind = (c == escnd_pkg::CH_HASH) ? escnd_pkg::KIND_HEX : escnd_pkg::KIND_DEC;
          esc_fill = 0;
        end else begin
          plain_rule(c);
        end
      end
    end
    if (last) begin
      if (step_res.size() == 0) add_res(8'h00, 1'b0, escnd_pkg::ERR_OK);
      step_res[step_res.size() - 1].end_of_line = 1'b1;
      clear_state();
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].run_last = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one char, wait for its transfer, then log the expected results.
  // Called and returns at a falling edge.
  task automatic push_char(input logic [7:0] c, input logic last, input logic typed,
                           input logic [7:0] t_byte, input logic t_valid,
                           input logic [1:0] t_err);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_char(c, last);
    if (typed) begin
      step_res.delete();
      step_res.push_back(decoded_t'{t_byte, t_valid, t_err, 1'b1, last});
    end
    foreach (step_res[i]) decoded_q.push_back(step_res[i]);
    chars_sent++;
    if (last) lines_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return escnd_pkg::CH_0 + 8'(r);
    if (r < 16) return escnd_pkg::CH_UA + 8'(r - 10);
    return escnd_pkg::CH_LA + 8'(r - 16);
  endfunction

  // Random line: mostly well-formed escapes and quoting, some noise;
  // truncation to the target length cuts escapes short at times
  task automatic send_line();
    logic [7:0] line_q [$];
    int target, r, bad;
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
    while (line_q.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        line_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end else if (r < 45) begin
        line_q.push_back(escnd_pkg::CH_SPACE);
      end else if (r < 55) begin
        line_q.push_back(escnd_pkg::CH_QUOTE);
        if ($urandom_range(0, 2) == 0) line_q.push_back(escnd_pkg::CH_QUOTE);
      end else if (r < 70) begin
        line_q.push_back(escnd_pkg::CH_HASH);
        line_q.push_back(hex_char());
        line_q.push_back(hex_char());
      end else if (r < 82) begin
        line_q.push_back(escnd_pkg::CH_AMP);
        repeat (3) line_q.push_back(escnd_pkg::CH_0 + 8'($urandom_range(0, 9)));
      end else if (r < 88) begin
        // escape with one digit spoiled
        bad = $urandom_range(1, 3);
        line_q.push_back($urandom_range(0, 1) ? escnd_pkg::CH_HASH : escnd_pkg::CH_AMP);
        for (int i = 1; i <= 3; i++)
          line_q.push_back(i == bad ? 8'($urandom_range(0, 255)) :
                           escnd_pkg::CH_0 + 8'($urandom_range(0, 9)));
      end else begin
        line_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    while (line_q.size() > target) void'(line_q.pop_back());
    foreach (line_q[i])
      push_char(line_q[i], i == line_q.size() - 1, 1'b0, 8'h00, 1'b0, escnd_pkg::ERR_OK);
  endtask

  // ---------------------------------------------------------------------
  // Receiver back-pressure
  // ---------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_hold = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_cnt++;
      if (m_tdata[10:9] != escnd_pkg::ERR_OK) errors_cnt++;
      if (decoded_q.size() == 0) begin
        $error("unexpected result transfer: tdata 0x%0h", m_tdata);
        fail_cnt++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte",    want.out_byte,    m_tdata[7:0]);
        check_field("byte_valid",  want.byte_valid,  m_tdata[8]);
        check_field("error_code",  want.error_code,  m_tdata[10:9]);
        check_field("run_last",    want.run_last,    m_tuser);
        check_field("end_of_line", want.end_of_line, m_tlast);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL escape_number_decoder");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int line_idx;
    clear_state();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows
    for (int i = 0; i < DIR_ROWS; i++)
      push_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed,
                dir_rows[i].t_byte, dir_rows[i].t_valid, dir_rows[i].t_err);

    // random lines, with stretches of no idling on either side
    line_idx = 0;
    while (chars_sent < DIR_ROWS + RANDOM_CHARS) begin
      no_idle = ((line_idx / 12) % 4) == 3;
      send_line();
      line_idx++;
    end
    no_idle = 1'b0;
    s_tvalid <= 1'b0;

    wait (decoded_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d chars in %0d lines; checked %0d results, %0d with a digit error.",
             chars_sent, lines_sent, results_cnt, errors_cnt);
    if (fail_cnt == 0) begin
      $display("PASS escape_number_decoder");
    end else begin
      $display("FAIL escape_number_decoder");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/escnd_pkg.sv
rtl/escnd_step.sv
rtl/escnd_outq.sv
rtl/escape_number_decoder.sv
verif/escape_number_decoder_test.sv
